// ===== rtl/core/record_marker_bounds_finder_defines.svh =====
// Assertion macros shared by the record marker bounds finder checkers.
// Depends on nothing; include by bare file name.
`ifndef RECORD_MARKER_BOUNDS_FINDER_DEFINES_SVH
`define RECORD_MARKER_BOUNDS_FINDER_DEFINES_SVH

// Implication in the same cycle, masked while reset is high.
`define RMBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Implication in the following cycle, masked while reset is high.
`define RMBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Implication in the following cycle, checked during reset as well.
`define RMBF_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/core/rmbf_pkg.sv =====
// Types, marker constants and offset helpers for the record marker bounds finder.
// Depends on nothing; used by every module of the block but the checker.
package rmbf_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int FIELD_BITS  = 32;
   localparam int WIN_LEN     = 15;
   localparam int START_LEN   = 15;
   localparam int END_LEN     = 13;
   localparam int WIN_BITS    = WIN_LEN * 8;
   localparam int START_BITS  = START_LEN * 8;
   localparam int END_BITS    = END_LEN * 8;
   localparam int FILL_BITS   = $clog2(WIN_LEN + 1);

   // oldest byte in the most significant position
   localparam logic [START_BITS-1:0] START_MARKER = {"# start record", 8'h0A};
   localparam logic [END_BITS-1:0]   END_MARKER   = {"# end record", 8'h0A};

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [WIN_BITS-1:0]    window_type;
   typedef logic [FILL_BITS-1:0]   fill_type;

   typedef struct packed {
      logic [7:0]            data_byte;
      logic [FIELD_BITS-1:0] byte_offset;
      logic                  last_byte;
   } req_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [FIELD_BITS-1:0] record_start;
      logic [FIELD_BITS-1:0] record_end;
   } res_type;

   function automatic offset_type to_offset(input logic [FIELD_BITS-1:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[OFFSET_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input offset_type value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/rmbf_req_reg.sv =====
// Request register: holds one incoming byte request ahead of the scanner.
// Depends on rmbf_pkg.
module rmbf_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic [31:0]      req_byte_offset,
   input  logic             req_last_byte,
   input  logic             advance,
   output logic             item_valid,
   output rmbf_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   rmbf_pkg::req_type item_ff;
   logic              in_free;

   assign in_free   = !valid_ff || advance;
   assign req_stall = !in_free;
   assign valid_in  = in_free ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         item_ff.data_byte   <= req_data_byte;
         item_ff.byte_offset <= req_byte_offset;
         item_ff.last_byte   <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/rmbf_scanner.sv =====
// Scanner: byte window, search phase, start position and marker compare.
// Depends on rmbf_pkg.
module rmbf_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rmbf_pkg::req_type item,
   output rmbf_pkg::res_type res
);

   rmbf_pkg::window_type window_ff, window_in, shifted;
   rmbf_pkg::fill_type   fill_ff, fill_in, fill_inc;
   logic                 seeking_end_ff, seeking_end_in;
   rmbf_pkg::offset_type start_position_ff, start_position_in;
   rmbf_pkg::offset_type offset;
   logic                 start_hit;
   logic                 end_hit;

   assign shifted  = {window_ff[rmbf_pkg::WIN_BITS-9:0], item.data_byte};
   assign fill_inc = (fill_ff == rmbf_pkg::FILL_BITS'(rmbf_pkg::WIN_LEN)) ?
                     fill_ff : fill_ff + 1'b1;
   assign offset   = rmbf_pkg::to_offset(item.byte_offset);

   assign start_hit = !seeking_end_ff
                   && (fill_inc >= rmbf_pkg::FILL_BITS'(rmbf_pkg::START_LEN))
                   && (shifted[rmbf_pkg::START_BITS-1:0] == rmbf_pkg::START_MARKER);
   assign end_hit   = seeking_end_ff
                   && (fill_inc >= rmbf_pkg::FILL_BITS'(rmbf_pkg::END_LEN))
                   && (shifted[rmbf_pkg::END_BITS-1:0] == rmbf_pkg::END_MARKER);

   always_comb begin
      window_in         = window_ff;
      fill_in           = fill_ff;
      seeking_end_in    = seeking_end_ff;
      start_position_in = start_position_ff;
      if (fire) begin
         if (start_hit) begin
            start_position_in = offset - rmbf_pkg::OFFSET_BITS'(rmbf_pkg::START_LEN - 1);
         end
         if (item.last_byte) begin
            window_in      = '0;
            fill_in        = '0;
            seeking_end_in = 1'b0;
         end else begin
            window_in      = shifted;
            fill_in        = fill_inc;
            seeking_end_in = start_hit ? 1'b1 : (end_hit ? 1'b0 : seeking_end_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff         <= '0;
         fill_ff           <= '0;
         seeking_end_ff    <= 1'b0;
         start_position_ff <= '0;
      end else begin
         window_ff         <= window_in;
         fill_ff           <= fill_in;
         seeking_end_ff    <= seeking_end_in;
         start_position_ff <= start_position_in;
      end
   end

   always_comb begin
      res.valid        = fire && (end_hit || item.last_byte);
      res.found        = end_hit;
      res.record_start = end_hit ? rmbf_pkg::to_field(start_position_ff) : '0;
      res.record_end   = end_hit ? rmbf_pkg::to_field(offset + 1'b1) : '0;
   end

endmodule

// ===== rtl/core/rmbf_rsp_reg.sv =====
// Response register: holds one result until the receiver takes it.
// Depends on rmbf_pkg.
module rmbf_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  rmbf_pkg::res_type res,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [31:0]       rsp_record_start,
   output logic [31:0]       rsp_record_end
);

   logic        valid_ff, valid_in;
   logic        found_ff;
   logic [31:0] start_ff;
   logic [31:0] end_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? res.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         found_ff <= res.found;
         start_ff <= res.record_start;
         end_ff   <= res.record_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_record_start = start_ff;
   assign rsp_record_end   = end_ff;

endmodule

// ===== rtl/core/record_marker_bounds_finder.sv =====
// Top level of the record marker bounds finder.
// Depends on rmbf_pkg, rmbf_req_reg, rmbf_scanner and rmbf_rsp_reg.
//
// Usage:
//   Request channel (req_*): one buffer byte per request with its offset and
//   an end-of-buffer flag. Response channel (rsp_*): at most one response per
//   request, either found with the record's start offset and the offset just
//   past the end marker, or not found (bounds zero) on a buffer's final byte
//   when that byte does not close a record.
//   Response path: an accepted request passes the request register, the
//   combinational scanner and the response register, and is taken when the receiver does not stall.
//   Throughput: one request per cycle while the receiver does not stall,
//   set by the combinational compare of the 15-byte window against both markers.
//   Reset: synchronous, active high; empties both registers, clears the
//   window, fill count, search phase and start position.
//   Stall: while rsp_stall holds a response, a further request is still
//   taken into the request register; req_stall rises only when both
//   registers are full and the response is not being taken.
module record_marker_bounds_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_byte_offset,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_record_start,
   output logic [31:0] rsp_record_end
);

   logic              advance;
   logic              item_valid;
   logic              fire;
   rmbf_pkg::req_type item;
   rmbf_pkg::res_type res;

   assign fire = item_valid && advance;

   rmbf_req_reg u_req_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_offset (req_byte_offset),
      .req_last_byte   (req_last_byte),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   rmbf_scanner u_scanner (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .res   (res)
   );

   rmbf_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .res              (res),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_record_start (rsp_record_start),
      .rsp_record_end   (rsp_record_end)
   );

endmodule

// ===== rtl/core/rmbf_checker.sv =====
// Port-level checker for the record marker bounds finder, bound to the top level.
// Depends on record_marker_bounds_finder_defines.svh and record_marker_bounds_finder.
`include "record_marker_bounds_finder_defines.svh"

module rmbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [31:0] rsp_record_start,
   input logic [31:0] rsp_record_end
);

   logic req_last_taken;

   assign req_last_taken = req_valid && !req_stall && req_last_byte;

   `RMBF_ASSERT_NEXT(rsp_held_when_stalled, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_record_start) && $stable(rsp_record_end))
   `RMBF_ASSERT_ALWAYS(rsp_empty_after_reset, clock, reset, !rsp_valid)
   `RMBF_ASSERT_SAME(not_found_bounds_zero, clock, reset, rsp_valid && !rsp_found, rsp_record_start == 32'd0 && rsp_record_end == 32'd0)
   `RMBF_ASSERT_NEXT(last_byte_gives_rsp, clock, reset, $past(req_last_taken) && (!rsp_valid || !rsp_stall), rsp_valid)

endmodule

bind record_marker_bounds_finder rmbf_checker u_rmbf_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for record_marker_bounds_finder: random buffers of marker text
// and noise are streamed in, and each response is checked against a local scan of the bytes.
// Depends on rmbf_pkg and the record_marker_bounds_finder RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned PHASE_ITEMS = 175;
   localparam logic [119:0] OPEN_TAG  = {"# start record", 8'h0A};
   localparam logic [103:0] CLOSE_TAG = {"# end record", 8'h0A};

   typedef struct packed {
      logic        found;
      logic [31:0] record_start;
      logic [31:0] record_end;
   } bounds_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic [31:0] req_byte_offset = 32'h0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_record_start;
   logic [31:0] rsp_record_end;

   rmbf_pkg::req_type byte_queue[$];
   bounds_type  bounds_due[$];
   logic [31:0] next_offset;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_queued = 0;
   int unsigned buffers_built = 0;
   int unsigned requests_taken = 0;
   int unsigned records_found = 0;
   int unsigned records_missing = 0;

   // scanner state
   logic [119:0] scan_window;
   int unsigned  scan_fill;
   bit           scan_in_record;
   logic [31:0]  scan_start;

   record_marker_bounds_finder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_offset  (req_byte_offset),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_record_start (rsp_record_start),
      .rsp_record_end   (rsp_record_end)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_scan();
      scan_window = '0;
      scan_fill = 0;
      scan_in_record = 1'b0;
      scan_start = '0;
   endfunction

   function automatic bit locate_bounds(input logic [7:0] data, input logic [31:0] offset,
                                        input logic last, output bounds_type bounds);
      bit given;
      given = 1'b0;
      bounds = '0;
      scan_window = {scan_window[111:0], data};
      if (scan_fill < 15) scan_fill++;
      if (!scan_in_record) begin
         if (scan_fill >= 15 && scan_window == OPEN_TAG) begin
            scan_start = offset - 32'd14;
            scan_in_record = 1'b1;
         end
      end else if (scan_fill >= 13 && scan_window[103:0] == CLOSE_TAG) begin
         bounds = '{found: 1'b1, record_start: scan_start, record_end: offset + 32'd1};
         given = 1'b1;
         scan_in_record = 1'b0;
      end
      if (last) begin
         given = 1'b1;
         scan_window = '0;
         scan_fill = 0;
         scan_in_record = 1'b0;
      end
      return given;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic logic [7:0] tag_byte(input bit closing, input int idx);
      return closing ? CLOSE_TAG[8*(12-idx) +: 8] : OPEN_TAG[8*(14-idx) +: 8];
   endfunction

   task automatic push_byte(input logic [7:0] data);
      byte_queue.push_back('{data_byte: data, byte_offset: next_offset, last_byte: 1'b0});
      next_offset = (next_offset == 32'hFFFF_FFFE) ? 32'h0 : next_offset + 32'd1;
      bytes_queued++;
   endtask

   // push the first count bytes of a marker, damaging the byte at flip_at if in range
   task automatic push_tag(input bit closing, input int count, input int flip_at);
      logic [7:0] data;
      for (int i = 0; i < count; i++) begin
         data = tag_byte(closing, i);
         if (i == flip_at) data = data ^ (8'h01 << $urandom_range(7));
         push_byte(data);
      end
   endtask

   task automatic push_noise(input int count);
      repeat (count) begin
         if ($urandom_range(2) == 0) begin
            if ($urandom_range(1)) push_byte(tag_byte(1'b1, $urandom_range(12)));
            else push_byte(tag_byte(1'b0, $urandom_range(14)));
         end else begin
            push_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic mark_last();
      rmbf_pkg::req_type tail;
      tail = byte_queue.pop_back();
      tail.last_byte = 1'b1;
      byte_queue.push_back(tail);
      buffers_built++;
   endtask

   task automatic build_buffer();
      case ($urandom_range(9))
         0: next_offset = $urandom_range(20);
         1: next_offset = 32'hFFFF_FFFE - $urandom_range(40);
         default: begin
            next_offset = $urandom;
            if (next_offset == 32'hFFFF_FFFF) next_offset = 32'hFFFF_FFFE;
         end
      endcase
      push_noise($urandom_range(6));
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            repeat ($urandom_range(1, 3)) begin
               push_tag(1'b0, 15, -1);
               push_noise($urandom_range(8));
               push_tag(1'b1, 13, -1);
               if ($urandom_range(1)) push_noise($urandom_range(4));
            end
         end
         6: begin
            push_tag(1'b0, $urandom_range(1, 14), -1);
            push_noise(1);
            push_tag(1'b0, 15, $urandom_range(14));
            push_tag(1'b0, 15, -1);
            push_tag(1'b1, 13, $urandom_range(12));
            push_tag(1'b1, $urandom_range(1, 12), -1);
            push_noise(1);
            push_tag(1'b1, 13, -1);
         end
         7: begin
            push_tag(1'b0, 15, -1);
            push_noise($urandom_range(10));
         end
         8: begin
            push_tag(1'b1, 13, -1);
            push_noise($urandom_range(3));
         end
         default: push_noise($urandom_range(1, 5));
      endcase
      if ($urandom_range(2) == 0) push_noise(1);
      mark_last();
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || bounds_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      rmbf_pkg::req_type item;
      bounds_type due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            requests_taken++;
            if (locate_bounds(req_data_byte, req_byte_offset, req_last_byte, due)) begin
               bounds_due.push_back(due);
            end
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               item = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data_byte;
               req_byte_offset <= item.byte_offset;
               req_last_byte <= item.last_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_responses
      bounds_type want;
      rsp_stall <= !reset && $urandom_range(99) < stall_pct;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (bounds_due.size() == 0) begin
               report_mismatch($sformatf("response with none due: found %b start %h end %h",
                                         rsp_found, rsp_record_start, rsp_record_end));
            end else begin
               want = bounds_due.pop_front();
               if (want.found) records_found++;
               else records_missing++;
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("found %b, want %b", rsp_found, want.found));
               if (rsp_record_start !== want.record_start)
                  report_mismatch($sformatf("record_start %h, want %h",
                                            rsp_record_start, want.record_start));
               if (rsp_record_end !== want.record_end)
                  report_mismatch($sformatf("record_end %h, want %h",
                                            rsp_record_end, want.record_end));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("[%0t] no traffic for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_idle[4];
      int unsigned phase_stall[4];
      int unsigned phase_base;
      phase_idle = '{0, 80, 0, 36};
      phase_stall = '{0, 0, 80, 36};
      clear_scan();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lone bytes at both offset extremes, then a record whose offsets wrap and jump,
      // closing on the final byte with its end bound at the top of the range
      next_offset = 32'h0;
      push_byte(8'hFF);
      mark_last();
      next_offset = 32'hFFFF_FFFE;
      push_byte(8'h00);
      mark_last();
      next_offset = 32'hFFFF_FFF8;
      push_tag(1'b0, 15, -1);
      next_offset = 32'hFFFF_FFF2;
      push_tag(1'b1, 13, -1);
      mark_last();
      drain();

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         phase_base = bytes_queued;
         while (bytes_queued - phase_base < PHASE_ITEMS) build_buffer();
         drain();
      end

      if (bounds_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", bounds_due.size()));
      $display("%0d buffers in %0d requests under four idle and stall mixes;",
               buffers_built, requests_taken);
      $display("%0d records located, %0d buffers ended without one",
               records_found, records_missing);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rmbf_pkg.sv
rtl/core/rmbf_req_reg.sv
rtl/core/rmbf_scanner.sv
rtl/core/rmbf_rsp_reg.sv
rtl/core/record_marker_bounds_finder.sv
rtl/core/rmbf_checker.sv
verif/testbench.sv
